// ===== sv/pca_pkg.sv =====
`timescale 1ns / 1ps

package pca_pkg;

    localparam int CHANNEL_BITS   = 16;
    localparam int GUARD_BITS     = 4;
    localparam int INT_FRAC       = CHANNEL_BITS + GUARD_BITS;
    localparam int REG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 3;

    // Working widths of the signed internal values, stage by stage
    localparam int W_GAIN = INT_FRAC + 4;
    localparam int W_CON  = INT_FRAC + 7;
    localparam int W_SAT  = W_CON + 4;
    localparam int W_IQ   = W_SAT + 2;
    localparam int W_ROT  = W_IQ + 3;
    localparam int W_RGB  = W_ROT + 3;

    localparam int TONE_STAGES = 4;
    localparam int HUE_STAGES  = 3;
    localparam int PIPE_DEPTH  = TONE_STAGES + HUE_STAGES + 1;

    typedef logic [CHANNEL_BITS-1:0] chan_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GAIN_RED   = 3'd0,
        REG_GAIN_GREEN = 3'd1,
        REG_GAIN_BLUE  = 3'd2,
        REG_CONTRAST   = 3'd3,
        REG_SATURATION = 3'd4,
        REG_HUE_COS    = 3'd5,
        REG_HUE_SIN    = 3'd6,
        REG_HUE_ENABLE = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [REG_BITS-1:0]        gain_red;
        logic [REG_BITS-1:0]        gain_green;
        logic [REG_BITS-1:0]        gain_blue;
        logic [REG_BITS-1:0]        contrast;
        logic [REG_BITS-1:0]        saturation;
        logic signed [REG_BITS-1:0] hue_cos;
        logic signed [REG_BITS-1:0] hue_sin;
        logic                       hue_enable;
    } pca_cfg_t;

    typedef struct packed {
        logic  valid;
        chan_t alpha;
    } pca_tag_t;

    localparam pca_cfg_t CFG_RESET = '{
        gain_red:   16'd8192,
        gain_green: 16'd8192,
        gain_blue:  16'd8192,
        contrast:   16'd16384,
        saturation: 16'd16384,
        hue_cos:    16'sd16384,
        hue_sin:    16'sd0,
        hue_enable: 1'b0
    };

    // Mid grey in the internal format
    localparam logic signed [INT_FRAC:0] HALF = (INT_FRAC+1)'(2**(INT_FRAC-1));

    localparam logic signed [15:0] RND13 = 16'sd4096;
    localparam logic signed [15:0] RND14 = 16'sd8192;
    localparam logic signed [17:0] RND16 = 18'sd32768;
    localparam logic signed [GUARD_BITS:0] RND_OUT = (GUARD_BITS+1)'(2**(GUARD_BITS-1));

    // Luminance and YIQ coefficients, Q.16
    localparam logic signed [17:0] K_Y_R = 18'sd19595;
    localparam logic signed [17:0] K_Y_G = 18'sd38470;
    localparam logic signed [17:0] K_Y_B = 18'sd7471;
    localparam logic signed [17:0] K_I_R = 18'sd39059;
    localparam logic signed [17:0] K_I_G = 18'sd17957;
    localparam logic signed [17:0] K_I_B = 18'sd21103;
    localparam logic signed [17:0] K_Q_R = 18'sd13828;
    localparam logic signed [17:0] K_Q_G = 18'sd34275;
    localparam logic signed [17:0] K_Q_B = 18'sd20447;
    localparam logic signed [17:0] K_R_I = 18'sd62652;
    localparam logic signed [17:0] K_R_Q = 18'sd40698;
    localparam logic signed [17:0] K_G_I = 18'sd17826;
    localparam logic signed [17:0] K_G_Q = 18'sd42402;
    localparam logic signed [17:0] K_B_I = 18'sd72483;
    localparam logic signed [17:0] K_B_Q = 18'sd111608;

    function automatic logic signed [W_SAT:0] luma(input logic signed [W_SAT-1:0] r,
                                                   input logic signed [W_SAT-1:0] g,
                                                   input logic signed [W_SAT-1:0] b);
        logic signed [W_SAT+19:0] acc;
        acc = r * K_Y_R + g * K_Y_G + b * K_Y_B + RND16;
        return acc[W_SAT+16:16];
    endfunction

endpackage

// ===== sv/pixel_color_adjust.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// -------   ------------------   -------------------------------------------
// pixel in  start / busy         in_red, in_green, in_blue, in_alpha
// pixel out done (1-cycle beat)  out_red, out_green, out_blue, out_alpha
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per clock; busy stays low. Each beat travels from start to done
// through four tone stages (gain, contrast, luma, saturation), three hue
// stages (to YIQ, rotate, back to RGB) and the round/clamp output register.
// The result is shown for one cycle and the receiver cannot stall; the
// pipeline advances on every clock. Reset clears valid bits and loads the
// register defaults.

module pixel_color_adjust (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pca_pkg::CHANNEL_BITS-1:0]    in_red,
    input  logic [pca_pkg::CHANNEL_BITS-1:0]    in_green,
    input  logic [pca_pkg::CHANNEL_BITS-1:0]    in_blue,
    input  logic [pca_pkg::CHANNEL_BITS-1:0]    in_alpha,
    output logic                                done,
    output logic [pca_pkg::CHANNEL_BITS-1:0]    out_red,
    output logic [pca_pkg::CHANNEL_BITS-1:0]    out_green,
    output logic [pca_pkg::CHANNEL_BITS-1:0]    out_blue,
    output logic [pca_pkg::CHANNEL_BITS-1:0]    out_alpha,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pca_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pca_pkg::REG_BITS-1:0]        cfg_data
);
    import pca_pkg::*;

    pca_cfg_t                cfg;
    pca_tag_t                tag_in;
    pca_tag_t                tone_tag;
    pca_tag_t                hue_tag;
    chan_t                   pix [3];
    logic signed [W_SAT-1:0] sat [3];
    logic signed [W_RGB-1:0] hue [3];
    logic signed [W_SAT-1:0] byp [3];
    chan_t                   out_reg [3];
    chan_t                   out_next [3];
    chan_t                   alpha_reg;
    logic                    done_reg;

    assign busy   = 1'b0;
    assign tag_in = '{valid: start, alpha: in_alpha};
    assign pix[0] = in_red;
    assign pix[1] = in_green;
    assign pix[2] = in_blue;

    pca_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pca_tone u_tone (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .tag_in  (tag_in),
        .pix_in  (pix),
        .tag_out (tone_tag),
        .sat_out (sat)
    );

    pca_hue u_hue (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .tag_in  (tone_tag),
        .sat_in  (sat),
        .tag_out (hue_tag),
        .hue_out (hue),
        .byp_out (byp)
    );

    always_comb
    begin
        logic signed [W_RGB-1:0]          v;
        logic signed [W_RGB-GUARD_BITS-1:0] c;
        for (int i = 0; i < 3; i++)
        begin
            v = cfg.hue_enable ? hue[i] : W_RGB'(byp[i]);
            v = v + RND_OUT;
            c = v[W_RGB-1:GUARD_BITS];
            // clamp to 0..full code
            if (c[W_RGB-GUARD_BITS-1])
            begin
                out_next[i] = '0;
            end
            else if (|c[W_RGB-GUARD_BITS-2:CHANNEL_BITS])
            begin
                out_next[i] = '1;
            end
            else
            begin
                out_next[i] = c[CHANNEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= hue_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        alpha_reg <= hue_tag.alpha;
    end

    assign done      = done_reg;
    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
    assign out_alpha = alpha_reg;

`ifndef SYNTHESIS
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_DEPTH))
        else $error("result beat without a matching start");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_DEPTH done)
        else $error("accepted pixel did not come out");

    a_alpha_path: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_alpha == $past(in_alpha, PIPE_DEPTH))
        else $error("alpha changed on its way through the pipeline");
`endif

endmodule

// ===== sv/pca_cfg.sv =====
`timescale 1ns / 1ps

module pca_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pca_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pca_pkg::REG_BITS-1:0]        cfg_data,
    output pca_pkg::pca_cfg_t                   cfg
);
    import pca_pkg::*;

    pca_cfg_t cfg_reg;
    pca_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_RED:   cfg_next.gain_red   = cfg_data;
                REG_GAIN_GREEN: cfg_next.gain_green = cfg_data;
                REG_GAIN_BLUE:  cfg_next.gain_blue  = cfg_data;
                REG_CONTRAST:   cfg_next.contrast   = cfg_data;
                REG_SATURATION: cfg_next.saturation = cfg_data;
                REG_HUE_COS:    cfg_next.hue_cos    = $signed(cfg_data);
                REG_HUE_SIN:    cfg_next.hue_sin    = $signed(cfg_data);
                REG_HUE_ENABLE: cfg_next.hue_enable = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/pca_tone.sv =====
`timescale 1ns / 1ps

module pca_tone (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pca_pkg::pca_cfg_t                   cfg,
    input  pca_pkg::pca_tag_t                   tag_in,
    input  pca_pkg::chan_t                      pix_in [3],
    output pca_pkg::pca_tag_t                   tag_out,
    output logic signed [pca_pkg::W_SAT-1:0]    sat_out [3]
);
    import pca_pkg::*;

    pca_tag_t                 tag_reg [TONE_STAGES];
    logic [REG_BITS-1:0]      gain_sel [3];
    logic signed [W_GAIN-1:0] gain_reg [3];
    logic signed [W_GAIN-1:0] gain_next [3];
    logic signed [W_CON-1:0]  con_reg [3];
    logic signed [W_CON-1:0]  con_next [3];
    logic signed [W_CON-1:0]  con_d_reg [3];
    logic signed [W_CON:0]    lum_reg;
    logic signed [W_CON:0]    lum_next;
    logic signed [W_SAT-1:0]  sat_reg [3];
    logic signed [W_SAT-1:0]  sat_next [3];

    assign gain_sel[0] = cfg.gain_red;
    assign gain_sel[1] = cfg.gain_green;
    assign gain_sel[2] = cfg.gain_blue;

    assign tag_out = tag_reg[TONE_STAGES-1];
    assign sat_out = sat_reg;

    always_comb
    begin
        logic signed [INT_FRAC+17:0] gp;
        logic signed [W_GAIN+17:0]   cp;
        logic signed [W_CON+18:0]    sp;
        logic signed [W_SAT:0]       lum_full;
        lum_full = luma(W_SAT'(con_reg[0]), W_SAT'(con_reg[1]), W_SAT'(con_reg[2]));
        lum_next = lum_full[W_CON:0];
        for (int i = 0; i < 3; i++)
        begin
            // gain, Q3.13
            gp = $signed({1'b0, pix_in[i], {GUARD_BITS{1'b0}}})
                 * $signed({1'b0, gain_sel[i]}) + RND13;
            gain_next[i] = gp[W_GAIN+12:13];
            // contrast about mid grey, Q2.14
            cp = (gain_reg[i] - HALF) * $signed({1'b0, cfg.contrast}) + RND14;
            con_next[i] = $signed(cp[W_CON+13:14]) + W_CON'(HALF);
            // saturation about luminance, Q2.14
            sp = (W_CON+19)'(con_d_reg[i]) - (W_CON+19)'(lum_reg);
            sp = sp * $signed({1'b0, cfg.saturation}) + RND14;
            sat_next[i] = W_SAT'(lum_reg) + $signed(sp[W_SAT+13:14]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < TONE_STAGES; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int s = 1; s < TONE_STAGES; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg  <= gain_next;
        con_reg   <= con_next;
        con_d_reg <= con_reg;
        lum_reg   <= lum_next;
        sat_reg   <= sat_next;
    end

endmodule

// ===== sv/pca_hue.sv =====
`timescale 1ns / 1ps

module pca_hue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pca_pkg::pca_cfg_t                   cfg,
    input  pca_pkg::pca_tag_t                   tag_in,
    input  logic signed [pca_pkg::W_SAT-1:0]    sat_in [3],
    output pca_pkg::pca_tag_t                   tag_out,
    output logic signed [pca_pkg::W_RGB-1:0]    hue_out [3],
    output logic signed [pca_pkg::W_SAT-1:0]    byp_out [3]
);
    import pca_pkg::*;

    pca_tag_t                tag_reg [HUE_STAGES];
    logic signed [W_SAT-1:0] byp1_reg [3];
    logic signed [W_SAT-1:0] byp2_reg [3];
    logic signed [W_SAT-1:0] byp3_reg [3];
    logic signed [W_SAT:0]   yy_reg;
    logic signed [W_SAT:0]   yy_next;
    logic signed [W_SAT:0]   yy_d_reg;
    logic signed [W_IQ-1:0]  ii_reg;
    logic signed [W_IQ-1:0]  ii_next;
    logic signed [W_IQ-1:0]  qq_reg;
    logic signed [W_IQ-1:0]  qq_next;
    logic signed [W_ROT-1:0] i2_reg;
    logic signed [W_ROT-1:0] i2_next;
    logic signed [W_ROT-1:0] q2_reg;
    logic signed [W_ROT-1:0] q2_next;
    logic signed [W_RGB-1:0] rgb_reg [3];
    logic signed [W_RGB-1:0] rgb_next [3];

    assign tag_out = tag_reg[HUE_STAGES-1];
    assign hue_out = rgb_reg;
    assign byp_out = byp3_reg;

    always_comb
    begin
        logic signed [W_SAT+19:0] ip;
        logic signed [W_SAT+19:0] qp;
        logic signed [W_IQ+16:0]  ir;
        logic signed [W_IQ+16:0]  qr;
        logic signed [W_ROT+18:0] rp;
        logic signed [W_ROT+18:0] gp;
        logic signed [W_ROT+18:0] bp;
        // into YIQ
        yy_next = luma(sat_in[0], sat_in[1], sat_in[2]);
        ip = sat_in[0] * K_I_R - sat_in[1] * K_I_G - sat_in[2] * K_I_B + RND16;
        qp = sat_in[0] * K_Q_R - sat_in[1] * K_Q_G + sat_in[2] * K_Q_B + RND16;
        ii_next = ip[W_IQ+15:16];
        qq_next = qp[W_IQ+15:16];
        // rotate the chroma plane, Q1.14
        ir = ii_reg * cfg.hue_cos - qq_reg * cfg.hue_sin + RND14;
        qr = ii_reg * cfg.hue_sin + qq_reg * cfg.hue_cos + RND14;
        i2_next = ir[W_ROT+13:14];
        q2_next = qr[W_ROT+13:14];
        // back to RGB
        rp = i2_reg * K_R_I + q2_reg * K_R_Q + RND16;
        gp = i2_reg * K_G_I + q2_reg * K_G_Q + RND16;
        bp = q2_reg * K_B_Q - i2_reg * K_B_I + RND16;
        rgb_next[0] = W_RGB'(yy_d_reg) + $signed(rp[W_RGB+15:16]);
        rgb_next[1] = W_RGB'(yy_d_reg) - $signed(gp[W_RGB+15:16]);
        rgb_next[2] = W_RGB'(yy_d_reg) + $signed(bp[W_RGB+15:16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < HUE_STAGES; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int s = 1; s < HUE_STAGES; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp1_reg <= sat_in;
        byp2_reg <= byp1_reg;
        byp3_reg <= byp2_reg;
        yy_reg   <= yy_next;
        yy_d_reg <= yy_reg;
        ii_reg   <= ii_next;
        qq_reg   <= qq_next;
        i2_reg   <= i2_next;
        q2_reg   <= q2_next;
        rgb_reg  <= rgb_next;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pca_pkg::*;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
        chan_t a;
    } pixel_t;

    // Rec.601 luma and YIQ coefficients, Q.16
    localparam longint Y_R = 19595;
    localparam longint Y_G = 38470;
    localparam longint Y_B = 7471;
    localparam longint I_R = 39059;
    localparam longint I_G = 17957;
    localparam longint I_B = 21103;
    localparam longint Q_R = 13828;
    localparam longint Q_G = 34275;
    localparam longint Q_B = 20447;
    localparam longint R_I = 62652;
    localparam longint R_Q = 40698;
    localparam longint G_I = 17826;
    localparam longint G_Q = 42402;
    localparam longint B_I = 72483;
    localparam longint B_Q = 111608;

    localparam longint MID_GREY  = 64'sd1 <<< (INT_FRAC - 1);
    localparam longint CODE_MAX  = (64'sd1 <<< CHANNEL_BITS) - 1;
    localparam int     DRAIN_MAX = 4 * PIPE_DEPTH + 16;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    logic                      busy;
    chan_t                     in_red    = '0;
    chan_t                     in_green  = '0;
    chan_t                     in_blue   = '0;
    chan_t                     in_alpha  = '0;
    logic                      done;
    chan_t                     out_red;
    chan_t                     out_green;
    chan_t                     out_blue;
    chan_t                     out_alpha;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]       cfg_data  = '0;

    pixel_t   px_pending[$];
    pixel_t   px_expected[$];
    pixel_t   px_on_port;
    pca_cfg_t tone_cfg = CFG_RESET;
    int       n_issued   = 0;
    int       n_accepted = 0;
    int       n_errors   = 0;
    int       gap_left   = 0;
    int       gap_pct    = 0;

    pixel_color_adjust dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .done      (done),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // floor((v + 2^(s-1)) / 2^s)
    function automatic longint scale_round(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint luma601(input longint r, input longint g, input longint b);
        return scale_round(Y_R * r + Y_G * g + Y_B * b, 16);
    endfunction

    function automatic chan_t to_code(input longint v);
        longint c;
        c = scale_round(v, GUARD_BITS);
        if (c < 0)
            return '0;
        if (c > CODE_MAX)
            return '1;
        return chan_t'(c);
    endfunction

    function automatic pixel_t color_adjust(input pixel_t px, input pca_cfg_t c);
        longint r, g, b, y, i, q, ir, qr;
        longint kr, kg, kb, ct, st, hc, hs;
        pixel_t res;
        kr = longint'(c.gain_red);
        kg = longint'(c.gain_green);
        kb = longint'(c.gain_blue);
        ct = longint'(c.contrast);
        st = longint'(c.saturation);
        hc = longint'(c.hue_cos);
        hs = longint'(c.hue_sin);
        r = longint'(px.r);
        g = longint'(px.g);
        b = longint'(px.b);
        r = scale_round((r <<< GUARD_BITS) * kr, 13);
        g = scale_round((g <<< GUARD_BITS) * kg, 13);
        b = scale_round((b <<< GUARD_BITS) * kb, 13);
        r = scale_round((r - MID_GREY) * ct, 14) + MID_GREY;
        g = scale_round((g - MID_GREY) * ct, 14) + MID_GREY;
        b = scale_round((b - MID_GREY) * ct, 14) + MID_GREY;
        y = luma601(r, g, b);
        r = y + scale_round((r - y) * st, 14);
        g = y + scale_round((g - y) * st, 14);
        b = y + scale_round((b - y) * st, 14);
        if (c.hue_enable)
        begin
            y  = luma601(r, g, b);
            i  = scale_round(I_R * r - I_G * g - I_B * b, 16);
            q  = scale_round(Q_R * r - Q_G * g + Q_B * b, 16);
            ir = scale_round(i * hc - q * hs, 14);
            qr = scale_round(i * hs + q * hc, 14);
            r  = y + scale_round(R_I * ir + R_Q * qr, 16);
            g  = y - scale_round(G_I * ir + G_Q * qr, 16);
            b  = y + scale_round(B_Q * qr - B_I * ir, 16);
        end
        res.r = to_code(r);
        res.g = to_code(g);
        res.b = to_code(b);
        res.a = px.a;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        n_errors++;
    endtask

    task automatic check_channel(input string name, input chan_t got, input chan_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Pixel driver: one beat per accepted start, with idle bursts at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            in_red   <= '0;
            in_green <= '0;
            in_blue  <= '0;
            in_alpha <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                px_expected.push_back(color_adjust(px_on_port, tone_cfg));
                n_accepted++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (px_pending.size() != 0 && $urandom_range(0, 99) < gap_pct)
                begin
                    gap_left = $urandom_range(0, 2);
                    start <= 1'b0;
                end
                else if (px_pending.size() != 0)
                begin
                    px_on_port = px_pending.pop_front();
                    start    <= 1'b1;
                    in_red   <= px_on_port.r;
                    in_green <= px_on_port.g;
                    in_blue  <= px_on_port.b;
                    in_alpha <= px_on_port.a;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: done is a single-cycle strobe, check every beat
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (px_expected.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel %h %h %h %h",
                                          out_red, out_green, out_blue, out_alpha));
            end
            else
            begin
                want = px_expected.pop_front();
                check_channel("red", out_red, want.r);
                check_channel("green", out_green, want.g);
                check_channel("blue", out_blue, want.b);
                check_channel("alpha", out_alpha, want.a);
            end
        end
    end

    task automatic queue_pixel(input chan_t r, input chan_t g, input chan_t b, input chan_t a);
        pixel_t p;
        p.r = r;
        p.g = g;
        p.b = b;
        p.a = a;
        px_pending.push_back(p);
        n_issued++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [REG_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN_RED:   tone_cfg.gain_red   = data;
            REG_GAIN_GREEN: tone_cfg.gain_green = data;
            REG_GAIN_BLUE:  tone_cfg.gain_blue  = data;
            REG_CONTRAST:   tone_cfg.contrast   = data;
            REG_SATURATION: tone_cfg.saturation = data;
            REG_HUE_COS:    tone_cfg.hue_cos    = data;
            REG_HUE_SIN:    tone_cfg.hue_sin    = data;
            REG_HUE_ENABLE: tone_cfg.hue_enable = data[0];
            default: ;
        endcase
    endtask

    // Hold until every pixel is in and every result is back or the drain guard expires
    task automatic wait_idle();
        int guard;
        guard = 0;
        while (n_accepted != n_issued)
            @(posedge clk);
        while (px_expected.size() != 0 && guard < DRAIN_MAX)
        begin
            @(posedge clk);
            guard++;
        end
        if (px_expected.size() != 0)
        begin
            report_mismatch($sformatf("%0d pixels never came out", px_expected.size()));
            px_expected.delete();
        end
    endtask

    function automatic logic [REG_BITS-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return REG_BITS'($urandom);
            default: return REG_BITS'($urandom_range(4096, 16384));
        endcase
    endfunction

    function automatic logic [REG_BITS-1:0] pick_factor();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'd49152;
            2:       return REG_BITS'($urandom);
            default: return REG_BITS'($urandom_range(0, 49152));
        endcase
    endfunction

    function automatic logic [REG_BITS-1:0] pick_trig();
        int v;
        v = $urandom_range(0, 32768) - 16384;
        if ($urandom_range(0, 7) == 0)
            return REG_BITS'($urandom);
        return v[REG_BITS-1:0];
    endfunction

    task automatic queue_random_pixel();
        chan_t r, g, b;
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                r = {CHANNEL_BITS{1'($urandom_range(0, 1))}};
                g = {CHANNEL_BITS{1'($urandom_range(0, 1))}};
                b = {CHANNEL_BITS{1'($urandom_range(0, 1))}};
            end
            1:
            begin
                g = r;
                b = r;
            end
            default: ;
        endcase
        queue_pixel(r, g, b, chan_t'($urandom));
    endtask

    initial
    begin
        int ph;
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: extremes and primaries
        gap_pct = 20;
        queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_pixel(16'h8000, 16'h8000, 16'h8000, 16'h5555);
        queue_pixel(16'h7FFF, 16'h8001, 16'h7FFE, 16'hAAAA);
        queue_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'h0001);
        queue_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h8000);
        queue_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF);
        queue_pixel(16'h0001, 16'h0002, 16'h0003, 16'hFFFE);
        queue_pixel(16'hFFFE, 16'h4000, 16'hC000, 16'h1234);
        wait_idle();

        // Full-scale legal codes, hue turned half a circle
        write_reg(REG_GAIN_RED, 16'hFFFF);
        write_reg(REG_GAIN_GREEN, 16'hFFFF);
        write_reg(REG_GAIN_BLUE, 16'hFFFF);
        write_reg(REG_CONTRAST, 16'd49152);
        write_reg(REG_SATURATION, 16'd49152);
        write_reg(REG_HUE_COS, 16'hC000);
        write_reg(REG_HUE_SIN, 16'd0);
        write_reg(REG_HUE_ENABLE, 16'h0001);
        queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        queue_pixel(16'h1000, 16'h0800, 16'h0400, 16'h0000);
        queue_pixel(16'hFFFF, 16'h0000, 16'h8000, 16'h00FF);
        queue_pixel(16'h2000, 16'h2000, 16'h2000, 16'hFF00);
        wait_idle();

        // Codes beyond the nominal ranges, enable with upper data bits set
        write_reg(REG_GAIN_RED, 16'h2000);
        write_reg(REG_GAIN_GREEN, 16'h1000);
        write_reg(REG_GAIN_BLUE, 16'h3000);
        write_reg(REG_CONTRAST, 16'hFFFF);
        write_reg(REG_SATURATION, 16'hFFFF);
        write_reg(REG_HUE_COS, 16'h8000);
        write_reg(REG_HUE_SIN, 16'h7FFF);
        write_reg(REG_HUE_ENABLE, 16'hFFFF);
        queue_pixel(16'h8000, 16'h8000, 16'h8000, 16'h0F0F);
        queue_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'hF0F0);
        queue_pixel(16'h0000, 16'hFFFF, 16'h8000, 16'h3C3C);
        queue_pixel(16'h7000, 16'h9000, 16'h8800, 16'hC3C3);
        wait_idle();

        // All zero but hue_sin; enable write with bit 0 clear must turn hue off
        write_reg(REG_GAIN_RED, 16'h0000);
        write_reg(REG_GAIN_GREEN, 16'h0000);
        write_reg(REG_GAIN_BLUE, 16'h0000);
        write_reg(REG_CONTRAST, 16'h0000);
        write_reg(REG_SATURATION, 16'h0000);
        write_reg(REG_HUE_COS, 16'h0000);
        write_reg(REG_HUE_SIN, 16'hC000);
        write_reg(REG_HUE_ENABLE, 16'hFFFE);
        queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        queue_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        queue_pixel(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        wait_idle();

        // Random settings, 50 pixels per setting; no idling in the last two
        for (ph = 0; ph < 10; ph++)
        begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_GAIN_RED, pick_gain());
            if ($urandom_range(0, 3) != 0) write_reg(REG_GAIN_GREEN, pick_gain());
            if ($urandom_range(0, 3) != 0) write_reg(REG_GAIN_BLUE, pick_gain());
            if ($urandom_range(0, 3) != 0) write_reg(REG_CONTRAST, pick_factor());
            if ($urandom_range(0, 3) != 0) write_reg(REG_SATURATION, pick_factor());
            if ($urandom_range(0, 3) != 0) write_reg(REG_HUE_COS, pick_trig());
            if ($urandom_range(0, 3) != 0) write_reg(REG_HUE_SIN, pick_trig());
            if ($urandom_range(0, 3) != 0) write_reg(REG_HUE_ENABLE, REG_BITS'($urandom));
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            if (ph >= 8)
                gap_pct = 0;
            for (k = 0; k < 50; k++)
                queue_random_pixel();
            wait_idle();
        end

        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
